>>> rtl/core/text_console_writer_unit_assert.svh
// Assertion macros shared by the console RTL.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tcw assertion failed");
`define TCW_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tcw assertion failed");
`else
`define TCW_ASSERT_IMP(lbl, pre, post)
`define TCW_ASSERT_NXT(lbl, pre, post)
`endif

`endif

>>> rtl/core/tcw_pkg.sv
package tcw_pkg;

  localparam int COLS_DEF     = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [1:0] FN_PRINT = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  typedef logic [2:0] cur_op_t;
  localparam cur_op_t CUR_HOLD = 3'd0;
  localparam cur_op_t CUR_HOME = 3'd1;  // column to zero
  localparam cur_op_t CUR_ADV  = 3'd2;  // step after a written char, wraps
  localparam cur_op_t CUR_LF   = 3'd3;  // column zero, next row unless last
  localparam cur_op_t CUR_BACK = 3'd4;  // one column left unless at zero

  typedef struct packed {
    logic last_col;
    logic last_row;
    logic col_zero;
  } cur_flags_t;

endpackage

>>> rtl/core/text_console_writer_unit.sv
// Text console: a COLS x ROWS screen of 16-bit entries (attribute high byte,
// character low byte) held in one on-chip memory, plus a cursor.
// Input channel (in_valid / in_stall): one command per item: print a
// character, read one screen position, clear the screen, or do nothing.
// Result channel (out_valid / out_stall): one result per command with the
// cursor column, row and linear position, and the read data (zero unless
// the command was an in-range read).
// Config channel (cfg_valid / cfg_ready, always ready): the attribute byte
// stored with written and cleared entries; write it only while idle.
// An accepted item runs through S_EXEC and S_FIN, with S_PUT between them
// for a printable character and once per space of a tab. One item
// is in flight at a time, so a new item is taken the cycle after the result
// is registered. The memory has one write port, so a scroll copies the
// entries one at a time and then blanks the last row, and a clear writes
// the entries one at a time.
// A stalled result is held in the output register; the next item is still
// taken and run, then the block waits in its last step with in_stall high
// until the held result is taken.
// Reset puts the cursor at row 0, column 0 and the attribute at 0x07; the
// screen contents are undefined until written or cleared.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLS     = COLS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_glyph,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_cursor_position,
  output logic [7:0]  out_read_glyph,
  output logic [7:0]  out_read_attr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_text_attribute
);

  localparam int CELLS = COLS * ROWS;
  localparam int MOVE  = CELLS - COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int PHW   = $clog2(TAB_STOP);
  localparam int TCW   = $clog2(TAB_STOP + 1);
  localparam int IW    = (AW > 11) ? AW : 11;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_SCRL  = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]     state_r, state_nxt;
  logic [1:0]     func_r, func_nxt;
  logic [7:0]     glyph_r, glyph_nxt;
  logic [10:0]    idx_r, idx_nxt;
  logic [7:0]     put_glyph_r, put_glyph_nxt;
  logic [TCW-1:0] tab_cnt_r, tab_cnt_nxt;
  logic [AW-1:0]  sc_r, sc_nxt;
  logic           cp_wr_r, cp_wr_nxt;
  logic [AW-1:0]  cp_waddr_r, cp_waddr_nxt;
  logic           rd_hit_r, rd_hit_nxt;
  logic [7:0]     attr_r;

  logic           out_valid_r, out_valid_nxt;
  logic [6:0]     out_col_r;
  logic [4:0]     out_row_r;
  logic [10:0]    out_pos_r;
  logic [7:0]     out_rg_r, out_ra_r;
  logic           out_load;

  logic [15:0]    mem [CELLS];
  logic [15:0]    rdata_r;
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata;

  cur_op_t        cur_op;
  cur_flags_t     flags;
  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic [AW-1:0]  base;
  logic [PHW-1:0] ph;
  logic [AW-1:0]  pos;
  logic [IW-1:0]  idx_w;
  logic [15:0]    blank;
  logic [TCW-1:0] cnt_dec;

  logic [CW+6:0]  col_wide;
  logic [RW+4:0]  row_wide;
  logic [AW+10:0] pos_wide;

  tcw_cursor #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (cur_op),
    .col_o   (col),
    .row_o   (row),
    .base_o  (base),
    .ph_o    (ph),
    .flags_o (flags)
  );

  assign pos     = base + AW'(col);
  assign idx_w   = IW'(idx_r);
  assign blank   = {attr_r, CH_SPACE};
  assign cnt_dec = tab_cnt_r - TCW'(1);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    glyph_nxt     = glyph_r;
    idx_nxt       = idx_r;
    put_glyph_nxt = put_glyph_r;
    tab_cnt_nxt   = tab_cnt_r;
    sc_nxt        = sc_r;
    cp_wr_nxt     = cp_wr_r;
    cp_waddr_nxt  = cp_waddr_r;
    rd_hit_nxt    = rd_hit_r;
    cur_op        = CUR_HOLD;
    we            = 1'b0;
    waddr         = pos;
    wdata         = blank;
    re            = 1'b0;
    raddr         = idx_w[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          glyph_nxt  = in_glyph;
          idx_nxt    = in_cell_index;
          rd_hit_nxt = 1'b0;
          sc_nxt     = '0;
          cp_wr_nxt  = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (func_r)
          FN_PRINT: begin
            priority if (glyph_r == CH_LF) begin
              cur_op      = CUR_LF;
              tab_cnt_nxt = '0;
              if (flags.last_row) state_nxt = S_SCRL;
            end else if (glyph_r == CH_CR) begin
              cur_op = CUR_HOME;
            end else if (glyph_r == CH_TAB) begin
              tab_cnt_nxt   = TCW'(TAB_STOP) - TCW'(ph);
              put_glyph_nxt = CH_SPACE;
              state_nxt     = S_PUT;
            end else if (glyph_r == CH_BS) begin
              if (!flags.col_zero) begin
                cur_op = CUR_BACK;
                we     = 1'b1;
                waddr  = pos - AW'(1);
              end
            end else begin
              tab_cnt_nxt   = TCW'(1);
              put_glyph_nxt = glyph_r;
              state_nxt     = S_PUT;
            end
          end
          FN_READ: begin
            if (idx_w < IW'(CELLS)) begin
              re         = 1'b1;
              rd_hit_nxt = 1'b1;
            end
          end
          FN_CLEAR: begin
            state_nxt = S_CLR;
          end
          default: begin
          end
        endcase
      end

      S_PUT: begin
        we          = 1'b1;
        wdata       = {attr_r, put_glyph_r};
        cur_op      = CUR_ADV;
        tab_cnt_nxt = cnt_dec;
        if (flags.last_col && flags.last_row) begin
          sc_nxt    = '0;
          cp_wr_nxt = 1'b0;
          state_nxt = S_SCRL;
        end else if (cnt_dec == '0) begin
          state_nxt = S_FIN;
        end
      end

      // read row below at sc_r, write the entry read last cycle one row up
      S_SCRL: begin
        we    = cp_wr_r;
        waddr = cp_waddr_r;
        wdata = rdata_r;
        if (sc_r < AW'(MOVE)) begin
          re           = 1'b1;
          raddr        = sc_r + AW'(COLS);
          cp_wr_nxt    = 1'b1;
          cp_waddr_nxt = sc_r;
          sc_nxt       = sc_r + AW'(1);
        end else begin
          cp_wr_nxt = 1'b0;
          state_nxt = S_BLANK;
        end
      end

      S_BLANK: begin
        we    = 1'b1;
        waddr = sc_r;
        if (sc_r == AW'(CELLS - 1)) begin
          state_nxt = (tab_cnt_r != '0) ? S_PUT : S_FIN;
        end else begin
          sc_nxt = sc_r + AW'(1);
        end
      end

      S_CLR: begin
        we    = 1'b1;
        waddr = sc_r;
        if (sc_r == AW'(CELLS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          sc_nxt = sc_r + AW'(1);
        end
      end

      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
      cp_wr_r     <= 1'b0;
      rd_hit_r    <= 1'b0;
      tab_cnt_r   <= '0;
      sc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cp_wr_r     <= cp_wr_nxt;
      rd_hit_r    <= rd_hit_nxt;
      tab_cnt_r   <= tab_cnt_nxt;
      sc_r        <= sc_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_text_attribute;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    glyph_r     <= glyph_nxt;
    idx_r       <= idx_nxt;
    put_glyph_r <= put_glyph_nxt;
    cp_waddr_r  <= cp_waddr_nxt;
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  assign col_wide = {7'd0, col};
  assign row_wide = {5'd0, row};
  assign pos_wide = {11'd0, pos};

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_col_r <= col_wide[6:0];
      out_row_r <= row_wide[4:0];
      out_pos_r <= pos_wide[10:0];
      out_rg_r  <= rd_hit_r ? rdata_r[7:0]  : 8'd0;
      out_ra_r  <= rd_hit_r ? rdata_r[15:8] : 8'd0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_col      = out_col_r;
  assign out_cursor_row      = out_row_r;
  assign out_cursor_position = out_pos_r;
  assign out_read_glyph      = out_rg_r;
  assign out_read_attr       = out_ra_r;

`include "text_console_writer_unit_assert.svh"

  `TCW_ASSERT_NXT(a_fin_holds, state_r == S_FIN && out_valid_r && out_stall, state_r == S_FIN)
  `TCW_ASSERT_IMP(a_put_count, state_r == S_PUT, tab_cnt_r != '0)
  `TCW_ASSERT_IMP(a_scroll_row, state_r == S_SCRL || state_r == S_BLANK, flags.last_row)

endmodule

>>> rtl/core/tcw_cursor.sv
module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLS     = COLS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF,
  localparam int CW      = $clog2(COLS),
  localparam int RW      = $clog2(ROWS),
  localparam int AW      = $clog2(COLS * ROWS),
  localparam int PHW     = $clog2(TAB_STOP)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cur_op_t        op,
  output logic [CW-1:0]  col_o,
  output logic [RW-1:0]  row_o,
  output logic [AW-1:0]  base_o,
  output logic [PHW-1:0] ph_o,
  output cur_flags_t     flags_o
);

  logic [CW-1:0]  col_r,  col_nxt;
  logic [RW-1:0]  row_r,  row_nxt;
  logic [AW-1:0]  base_r, base_nxt;   // row_r * COLS
  logic [PHW-1:0] ph_r,   ph_nxt;     // col_r modulo TAB_STOP
  logic [PHW-1:0] ph_inc, ph_dec;

  assign flags_o.last_col = (col_r == CW'(COLS - 1));
  assign flags_o.last_row = (row_r == RW'(ROWS - 1));
  assign flags_o.col_zero = (col_r == '0);

  assign ph_inc = (ph_r == PHW'(TAB_STOP - 1)) ? '0 : ph_r + PHW'(1);
  assign ph_dec = (ph_r == '0) ? PHW'(TAB_STOP - 1) : ph_r - PHW'(1);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    ph_nxt   = ph_r;
    unique case (op)
      CUR_HOLD: begin
      end
      CUR_HOME: begin
        col_nxt = '0;
        ph_nxt  = '0;
      end
      CUR_BACK: begin
        if (!flags_o.col_zero) begin
          col_nxt = col_r - CW'(1);
          ph_nxt  = ph_dec;
        end
      end
      CUR_LF, CUR_ADV: begin
        if (op == CUR_ADV && !flags_o.last_col) begin
          col_nxt = col_r + CW'(1);
          ph_nxt  = ph_inc;
        end else begin
          col_nxt = '0;
          ph_nxt  = '0;
          // on the last row the cursor keeps its row; the scroll moves the text up
          if (!flags_o.last_row) begin
            row_nxt  = row_r + RW'(1);
            base_nxt = base_r + AW'(COLS);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      base_r <= '0;
      ph_r   <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
      ph_r   <= ph_nxt;
    end
  end

  assign col_o  = col_r;
  assign row_o  = row_r;
  assign base_o = base_r;
  assign ph_o   = ph_r;

`include "text_console_writer_unit_assert.svh"

  `TCW_ASSERT_IMP(a_col_range, 1'b1, int'(col_r) < COLS)
  `TCW_ASSERT_IMP(a_row_range, 1'b1, int'(row_r) < ROWS)
  `TCW_ASSERT_IMP(a_base_match, 1'b1, int'(base_r) == int'(row_r) * COLS)

endmodule

>>> sim/console_screen_checker.sv
module console_screen_checker
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_glyph,
  input  logic [10:0] in_cell_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [6:0]  out_cursor_col,
  input  logic [4:0]  out_cursor_row,
  input  logic [10:0] out_cursor_position,
  input  logic [7:0]  out_read_glyph,
  input  logic [7:0]  out_read_attr,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_text_attribute,
  output int          fail_count,
  output int          pending_results,
  output int          scroll_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = COLS_DEF * ROWS_DEF;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] position;
    logic [7:0]  glyph;
    logic [7:0]  attr;
  } console_status_t;

  // attribute in the high byte, character in the low byte
  logic [15:0]     screen [CELLS];
  int unsigned     col_now;
  int unsigned     row_now;
  logic [7:0]      attr_now;
  console_status_t awaited [$];

  function automatic logic [15:0] blank_cell();
    return {attr_now, CH_SPACE};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLS_DEF; i++)
      screen[i] = screen[i + COLS_DEF];
    for (int i = CELLS - COLS_DEF; i < CELLS; i++)
      screen[i] = blank_cell();
    row_now = ROWS_DEF - 1;
    scroll_count++;
  endfunction

  function automatic void line_feed();
    col_now = 0;
    row_now++;
    if (row_now >= ROWS_DEF)
      scroll_screen();
  endfunction

  function automatic void put_glyph(logic [7:0] g);
    screen[row_now * COLS_DEF + col_now] = {attr_now, g};
    col_now++;
    if (col_now >= COLS_DEF)
      line_feed();
  endfunction

  function automatic void print_glyph(logic [7:0] g);
    int unsigned spaces;
    case (g)
      CH_LF: line_feed();
      CH_CR: col_now = 0;
      CH_TAB: begin
        // count fixed up front; the spaces may wrap and scroll
        spaces = TAB_STOP_DEF - (col_now % TAB_STOP_DEF);
        repeat (spaces) put_glyph(CH_SPACE);
      end
      CH_BS: begin
        if (col_now != 0) begin
          col_now--;
          screen[row_now * COLS_DEF + col_now] = blank_cell();
        end
      end
      default: put_glyph(g);
    endcase
  endfunction

  function automatic console_status_t run_command(logic [1:0] fn, logic [7:0] g,
                                                  logic [10:0] idx);
    console_status_t s;
    s = '0;
    case (fn)
      FN_PRINT: print_glyph(g);
      FN_READ: begin
        if (idx < CELLS)
          {s.attr, s.glyph} = screen[idx];
      end
      FN_CLEAR: begin
        for (int i = 0; i < CELLS; i++)
          screen[i] = blank_cell();
      end
      default: ;
    endcase
    s.col      = col_now[6:0];
    s.row      = row_now[4:0];
    s.position = 11'(row_now * COLS_DEF + col_now);
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 100)
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    console_status_t want;
    if (!rst_n) begin
      awaited.delete();
      col_now = 0;
      row_now = 0;
      attr_now = ATTR_RESET;
      pending_results <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        attr_now = cfg_text_attribute;
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          report_mismatch("unexpected item, cursor_position", out_cursor_position, -1);
        end else begin
          want = awaited.pop_front();
          if (out_cursor_col !== want.col)
            report_mismatch("cursor_col", out_cursor_col, want.col);
          if (out_cursor_row !== want.row)
            report_mismatch("cursor_row", out_cursor_row, want.row);
          if (out_cursor_position !== want.position)
            report_mismatch("cursor_position", out_cursor_position, want.position);
          if (out_read_glyph !== want.glyph)
            report_mismatch("read_glyph", out_read_glyph, want.glyph);
          if (out_read_attr !== want.attr)
            report_mismatch("read_attr", out_read_attr, want.attr);
        end
      end
      if (in_valid && !in_stall)
        awaited.push_back(run_command(in_func, in_glyph, in_cell_index));
      pending_results <= awaited.size();
    end
  end

endmodule

>>> sim/tb_text_console_writer_unit.sv
module tb_text_console_writer_unit
  import tcw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FN_NOOP     = 2'd3;
  localparam int         CELLS       = COLS_DEF * ROWS_DEF;
  localparam int         IDLE_LIMIT  = 20000;
  localparam int         PHASE_ITEMS = 500;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [7:0]  in_glyph;
  logic [10:0] in_cell_index;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_cursor_col;
  logic [4:0]  out_cursor_row;
  logic [10:0] out_cursor_position;
  logic [7:0]  out_read_glyph;
  logic [7:0]  out_read_attr;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_text_attribute;

  int fail_count;
  int pending_results;
  int scroll_count;
  int gap_pct;
  int stall_pct;
  int idle_cycles;
  int n_print, n_read, n_clear, n_noop;

  always #6 clk = ~clk;

  text_console_writer_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_glyph            (in_glyph),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_col      (out_cursor_col),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_position (out_cursor_position),
    .out_read_glyph      (out_read_glyph),
    .out_read_attr       (out_read_attr),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_text_attribute  (cfg_text_attribute)
  );

  console_screen_checker screen_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_glyph            (in_glyph),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_col      (out_cursor_col),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_position (out_cursor_position),
    .out_read_glyph      (out_read_glyph),
    .out_read_attr       (out_read_attr),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_text_attribute  (cfg_text_attribute),
    .fail_count          (fail_count),
    .pending_results     (pending_results),
    .scroll_count        (scroll_count)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_cmd(input logic [1:0] fn, input logic [7:0] g, input logic [10:0] idx);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= fn;
    in_glyph      <= g;
    in_cell_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (fn)
      FN_PRINT: n_print++;
      FN_READ:  n_read++;
      FN_CLEAR: n_clear++;
      default:  n_noop++;
    endcase
  endtask

  // pending_results is registered, so the clock steps before each check
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic set_attribute(input logic [7:0] a);
    cfg_valid          <= 1'b1;
    cfg_text_attribute <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // screen is fully written by the directed clear, so any read is legal here
  task automatic push_random_cmd();
    int kind;
    int sub;
    logic [7:0] g;
    logic [10:0] idx;
    kind = $urandom_range(99);
    sub  = $urandom_range(99);
    if (kind < 75) begin
      if (sub < 60)      g = 8'($urandom_range(126, 32));
      else if (sub < 72) g = 8'($urandom);
      else if (sub < 82) g = CH_LF;
      else if (sub < 87) g = CH_CR;
      else if (sub < 94) g = CH_TAB;
      else               g = CH_BS;
      push_cmd(FN_PRINT, g, 11'($urandom));
    end else if (kind < 95) begin
      if (sub < 90) idx = 11'($urandom_range(CELLS - 1));
      else          idx = 11'($urandom_range(2047, CELLS));
      push_cmd(FN_READ, 8'($urandom), idx);
    end else if (kind < 97) begin
      push_cmd(FN_CLEAR, 8'($urandom), 11'($urandom));
    end else begin
      push_cmd(FN_NOOP, 8'($urandom), 11'($urandom));
    end
  endtask

  initial begin
    logic [7:0] attr_plan [4];
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_func            <= FN_PRINT;
    in_glyph           <= 8'h00;
    in_cell_index      <= 11'd0;
    cfg_valid          <= 1'b0;
    cfg_text_attribute <= ATTR_RESET;
    stall_pct          <= 0;
    gap_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset attribute; only cell 0 is readable before the clear
    push_cmd(FN_PRINT, 8'h00, 11'h7FF);
    push_cmd(FN_READ,  8'hFF, 11'd0);
    push_cmd(FN_READ,  8'h00, 11'h7FF);
    push_cmd(FN_READ,  8'h00, 11'(CELLS));
    push_cmd(FN_CLEAR, 8'h00, 11'd0);
    push_cmd(FN_READ,  8'h00, 11'(CELLS - 1));
    push_cmd(FN_NOOP,  8'hFF, 11'd0);
    push_cmd(FN_PRINT, CH_BS, 11'd0);
    push_cmd(FN_PRINT, CH_BS, 11'd0);
    push_cmd(FN_PRINT, 8'hFF, 11'd0);
    push_cmd(FN_PRINT, 8'h7E, 11'd0);
    push_cmd(FN_PRINT, CH_TAB, 11'd0);
    push_cmd(FN_PRINT, CH_TAB, 11'd0);
    push_cmd(FN_PRINT, CH_CR, 11'd0);
    push_cmd(FN_PRINT, CH_LF, 11'd0);
    push_cmd(FN_PRINT, 8'h41, 11'd0);
    push_cmd(FN_READ,  8'h00, 11'(COLS_DEF));
    push_cmd(FN_READ,  8'h00, 11'd1);
    push_cmd(FN_READ,  8'h00, 11'd8);

    attr_plan = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    for (int p = 0; p < 4; p++) begin
      drain_results();
      set_attribute(attr_plan[p]);
      gap_pct = (p == 1) ? 80 : (p == 3) ? 23 : 0;
      stall_pct <= (p == 2) ? 80 : (p == 3) ? 23 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // at mid-phase and at random, the sender holds off until the block has answered everything
        if (n == PHASE_ITEMS / 2 || $urandom_range(199) == 0)
          drain_results();
        push_random_cmd();
      end
    end
    drain_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d commands: %0d prints, %0d reads, %0d clears, %0d no-ops, %0d scrolls.",
             n_print + n_read + n_clear + n_noop, n_print, n_read, n_clear, n_noop,
             scroll_count);
    $display("Attributes 0x07, 0x00, 0xFF and two random; phases with and without idling.");
    if (fail_count == 0 && pending_results == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> text_console_writer_unit.f
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_cursor.sv
rtl/core/text_console_writer_unit.sv
sim/console_screen_checker.sv
sim/tb_text_console_writer_unit.sv
